// File: rtl/rgbalu_pkg.sv
// ----------------------------------------------------------------------------
// rgbalu_pkg
// Shared widths, operation codes and item types for the pixel ALU.
// ----------------------------------------------------------------------------
package rgbalu_pkg;

    localparam int C_CHAN_W  = 8;
    localparam int C_KIND_W  = 5;
    localparam int C_LEN_W   = 9;
    localparam int C_SQS_W   = 18;
    localparam int C_PROD_W  = 16;

    typedef enum logic [C_KIND_W-1:0] {
        K_ADD  = 5'd0,
        K_SUB  = 5'd1,
        K_ABSD = 5'd2,
        K_OR   = 5'd3,
        K_XOR  = 5'd4,
        K_AND  = 5'd5,
        K_DIV  = 5'd6,
        K_MOD  = 5'd7,
        K_MUL  = 5'd8,
        K_SHL  = 5'd9,
        K_SHR  = 5'd10,
        K_INV  = 5'd11,
        K_INC  = 5'd12,
        K_DEC  = 5'd13,
        K_RBG  = 5'd14,
        K_GRB  = 5'd15,
        K_GBR  = 5'd16,
        K_BRG  = 5'd17,
        K_BGR  = 5'd18
    } t_kind;

    typedef logic [2:0][C_CHAN_W-1:0] t_pix;

endpackage

// File: rtl/rgbalu_div.sv
// ----------------------------------------------------------------------------
// rgbalu_div
// Pipelined 8-bit restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module rgbalu_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rgbalu_pkg::C_CHAN_W-1:0] i_num,
    input  logic [rgbalu_pkg::C_CHAN_W-1:0] i_den,
    output logic [rgbalu_pkg::C_CHAN_W-1:0] o_quo,
    output logic [rgbalu_pkg::C_CHAN_W-1:0] o_rem
);
    localparam int W      = rgbalu_pkg::C_CHAN_W;
    localparam int STAGES = W / 2;

    logic [W-1:0] r_nq  [STAGES];
    logic [W-1:0] r_rem [STAGES];
    logic [W-1:0] r_den [STAGES];
    logic [W-1:0] n_nq  [STAGES];
    logic [W-1:0] n_rem [STAGES];
    logic [W-1:0] w_nq_in  [STAGES];
    logic [W-1:0] w_rem_in [STAGES];
    logic [W-1:0] w_den_in [STAGES];

    // Stage sources: the first stage takes the operands, later ones the
    // previous stage.
    for (genvar s = 0; s < STAGES; s++) begin : g_src
        if (s == 0) begin : g_first
            assign w_nq_in[s]  = i_num;
            assign w_rem_in[s] = '0;
            assign w_den_in[s] = i_den;
        end else begin : g_next
            assign w_nq_in[s]  = r_nq[s-1];
            assign w_rem_in[s] = r_rem[s-1];
            assign w_den_in[s] = r_den[s-1];
        end
    end

    always_comb begin
        logic [W-1:0] nq;
        logic [W-1:0] rm;
        logic [W:0]   t;
        for (int s = 0; s < STAGES; s++) begin
            nq = w_nq_in[s];
            rm = w_rem_in[s];
            for (int j = 0; j < 2; j++) begin
                t  = {rm, nq[W-1]};
                nq = {nq[W-2:0], 1'b0};
                if (t >= {1'b0, w_den_in[s]}) begin
                    t     = t - {1'b0, w_den_in[s]};
                    nq[0] = 1'b1;
                end
                rm = t[W-1:0];
            end
            n_nq[s]  = nq;
            n_rem[s] = rm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STAGES; s++) begin
                r_nq[s]  <= n_nq[s];
                r_rem[s] <= n_rem[s];
                r_den[s] <= w_den_in[s];
            end
        end
    end

    assign o_quo = r_nq[STAGES-1];
    assign o_rem = r_rem[STAGES-1];

endmodule

// File: rtl/saturating_rgb_pixel_alu.sv
// ----------------------------------------------------------------------------
// saturating_rgb_pixel_alu
// Per-channel saturating RGB arithmetic with comparisons and channel stats.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tdata carries pixel A, pixel B and the scalar operand;
//   tuser carries the operation code and the scalar select flag. Each
//   accepted transaction yields exactly one master transaction carrying
//   the three result channels, the five all-channel compare flags, and
//   min, max, average and Euclidean length of A.
//   Data passes the stage registers and the output register. Throughput:
//   one pixel per clock unless stalled. The critical work (8-bit divide at
//   two bits per stage, 9-bit square root over four stages) sets the depth.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits and the
//   output valid; payload registers are not reset.
//   When the receiver stalls with a result held, the whole pipeline holds
//   and o_s_axis_tready drops; nothing is lost or repeated. While the
//   output register is empty or being drained, the pipeline advances.
// ----------------------------------------------------------------------------
module saturating_rgb_pixel_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // a_red, a_green, a_blue, b_red, b_green, b_blue, scalar_operand
    input  logic [55:0] i_s_axis_tdata,
    // kind[4:0], use_scalar[5]
    input  logic [5:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue, all_greater, all_less, all_greater_equal,
    // all_less_equal, all_equal, min_channel, max_channel, average_channel,
    // vector_length, zero pad
    output logic [63:0] o_m_axis_tdata
);
    localparam int CW = rgbalu_pkg::C_CHAN_W;
    localparam int NS = 5;   // stages ahead of the output register

    typedef struct packed {
        rgbalu_pkg::t_kind                           kind;
        logic                                        scal;
        rgbalu_pkg::t_pix                            a;
        rgbalu_pkg::t_pix                            b;
        rgbalu_pkg::t_pix                            x;
        logic [2:0][rgbalu_pkg::C_PROD_W-1:0]        sq;
        logic [2:0][rgbalu_pkg::C_PROD_W-1:0]        prod;
        logic [4:0]                                  flags;  // gt lt ge le eq
        logic [CW-1:0]                               mn;
        logic [CW-1:0]                               mx;
        logic [CW-1:0]                               avg;
        rgbalu_pkg::t_pix                            mulq;
        logic [rgbalu_pkg::C_SQS_W-1:0]              rem;
        logic [rgbalu_pkg::C_LEN_W-1:0]              root;
    } t_item;

    t_item       r_st [NS];
    t_item       n_st [NS];
    logic [NS-1:0] r_vld;
    logic        r_ovld;
    logic [63:0] r_odata;
    logic [63:0] n_odata;
    logic        w_en;
    rgbalu_pkg::t_pix w_quo;
    rgbalu_pkg::t_pix w_rem;

    // One digit of the square root: try setting root bit i against the
    // remaining radicand.
    function automatic t_item sqrt_step(input t_item it, input int i);
        logic [19:0] t;
        t_item       o;
        o = it;
        t = ({11'd0, it.root} << (i + 1)) | (20'd1 << (2 * i));
        if ({2'b00, it.rem} >= t) begin
            o.rem  = it.rem - t[rgbalu_pkg::C_SQS_W-1:0];
            o.root = it.root | (rgbalu_pkg::C_LEN_W'(1) << i);
        end
        return o;
    endfunction

    function automatic logic [CW-1:0] chan_res(
        input rgbalu_pkg::t_kind k, input logic [CW-1:0] a, input logic [CW-1:0] x,
        input logic scal, input logic [rgbalu_pkg::C_PROD_W-1:0] prod,
        input logic [CW-1:0] mq, input logic [CW-1:0] q, input logic [CW-1:0] r);
        logic [CW:0]   s9;
        logic [15:0]   sh;
        logic [CW-1:0] res;
        s9 = {1'b0, a} + {1'b0, x};
        sh = {8'd0, a} << x[2:0];
        case (k)
            rgbalu_pkg::K_ADD:  res = s9[CW] ? '1 : s9[CW-1:0];
            rgbalu_pkg::K_SUB:  res = (a > x) ? a - x : '0;
            rgbalu_pkg::K_ABSD: res = (a > x) ? a - x : x - a;
            rgbalu_pkg::K_OR:   res = a | x;
            rgbalu_pkg::K_XOR:  res = a ^ x;
            rgbalu_pkg::K_AND:  res = a & x;
            rgbalu_pkg::K_DIV:  res = (x == '0) ? a : q;
            rgbalu_pkg::K_MOD:  res = (x == '0) ? (scal ? a : '0) : r;
            rgbalu_pkg::K_MUL:  res = scal ? ((prod > 16'd255) ? '1 : prod[CW-1:0]) : mq;
            rgbalu_pkg::K_SHL: begin
                if (a == '0)             res = '0;
                else if (x >= 8'd8)      res = '1;
                else if (sh > 16'd255)   res = '1;
                else                     res = sh[CW-1:0];
            end
            rgbalu_pkg::K_SHR:  res = (x >= 8'd8) ? '0 : (a >> x[2:0]);
            rgbalu_pkg::K_INV:  res = ~a;
            rgbalu_pkg::K_INC:  res = a + 8'd1;
            rgbalu_pkg::K_DEC:  res = a - 8'd1;
            default:            res = a;
        endcase
        return res;
    endfunction

    // Stall everything only while a finished result waits at the output.
    assign w_en            = !r_ovld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    for (genvar c = 0; c < 3; c++) begin : g_div
        rgbalu_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_st[0].a[c]),
            .i_den (r_st[0].x[c]),
            .o_quo (w_quo[c]),
            .o_rem (w_rem[c])
        );
    end

    always_comb begin
        logic [16:0] w;
        logic [CW:0] rc;
        logic [9:0]  s10;
        logic [19:0] avgp;
        logic        gt, lt, ge, le, eq;
        logic [CW-1:0] mn, mx;
        rgbalu_pkg::t_pix res;
        rgbalu_pkg::t_pix ra;

        // Stage 1: capture operands, form products.
        n_st[0]      = r_st[0];
        n_st[0].kind = rgbalu_pkg::t_kind'(i_s_axis_tuser[4:0]);
        n_st[0].scal = i_s_axis_tuser[5];
        for (int c = 0; c < 3; c++) begin
            n_st[0].a[c]    = i_s_axis_tdata[c*CW +: CW];
            n_st[0].b[c]    = i_s_axis_tdata[(c+3)*CW +: CW];
            n_st[0].x[c]    = i_s_axis_tuser[5] ? i_s_axis_tdata[6*CW +: CW]
                                                : i_s_axis_tdata[(c+3)*CW +: CW];
            n_st[0].sq[c]   = n_st[0].a[c] * n_st[0].a[c];
            n_st[0].prod[c] = n_st[0].a[c] * n_st[0].x[c];
        end

        // Stage 2: compares, stats, pixel multiply scaling, first root bits.
        n_st[1] = r_st[0];
        gt = 1'b1; lt = 1'b1; ge = 1'b1; le = 1'b1; eq = 1'b1;
        mn = r_st[0].a[0];
        mx = r_st[0].a[0];
        for (int c = 0; c < 3; c++) begin
            gt = gt && (r_st[0].a[c] >  r_st[0].b[c]);
            lt = lt && (r_st[0].a[c] <  r_st[0].b[c]);
            ge = ge && (r_st[0].a[c] >= r_st[0].b[c]);
            le = le && (r_st[0].a[c] <= r_st[0].b[c]);
            eq = eq && (r_st[0].a[c] == r_st[0].b[c]);
            if (r_st[0].a[c] < mn) mn = r_st[0].a[c];
            if (r_st[0].a[c] > mx) mx = r_st[0].a[c];
            // round(a*b/255): w = a*b + 127, w/255 via w>>8 plus one correction
            w  = {1'b0, r_st[0].prod[c]} + 17'd127;
            rc = {1'b0, w[15:8]} + {1'b0, w[7:0]};
            n_st[1].mulq[c] = w[15:8] + ((rc >= 9'd255) ? 8'd1 : 8'd0);
        end
        n_st[1].flags = {eq, le, ge, lt, gt};
        n_st[1].mn    = mn;
        n_st[1].mx    = mx;
        s10  = {2'b00, r_st[0].a[0]} + {2'b00, r_st[0].a[1]} + {2'b00, r_st[0].a[2]};
        avgp = s10 * 10'd683;
        n_st[1].avg  = avgp[18:11];
        n_st[1].rem  = {2'b00, r_st[0].sq[0]} + {2'b00, r_st[0].sq[1]}
                     + {2'b00, r_st[0].sq[2]};
        n_st[1].root = '0;
        n_st[1] = sqrt_step(n_st[1], 8);
        n_st[1] = sqrt_step(n_st[1], 7);

        // Stages 3..5: remaining root bits.
        n_st[2] = sqrt_step(sqrt_step(r_st[1], 6), 5);
        n_st[3] = sqrt_step(sqrt_step(r_st[2], 4), 3);
        n_st[4] = sqrt_step(sqrt_step(sqrt_step(r_st[3], 2), 1), 0);

        // Output stage: pick the channel result.
        ra = r_st[4].a;
        for (int c = 0; c < 3; c++) begin
            res[c] = chan_res(r_st[4].kind, ra[c], r_st[4].x[c], r_st[4].scal,
                              r_st[4].prod[c], r_st[4].mulq[c], w_quo[c], w_rem[c]);
        end
        case (r_st[4].kind)
            rgbalu_pkg::K_RBG: res = {ra[1], ra[2], ra[0]};
            rgbalu_pkg::K_GRB: res = {ra[2], ra[0], ra[1]};
            rgbalu_pkg::K_GBR: res = {ra[0], ra[2], ra[1]};
            rgbalu_pkg::K_BRG: res = {ra[1], ra[0], ra[2]};
            rgbalu_pkg::K_BGR: res = {ra[0], ra[1], ra[2]};
            default:           res = res;
        endcase
        n_odata = {2'b00, r_st[4].root, r_st[4].avg, r_st[4].mx, r_st[4].mn,
                   r_st[4].flags, res};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[NS-2:0], i_s_axis_tvalid};
            r_ovld <= r_vld[NS-1];
        end
    end

    // Advance payload with the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NS; s++) begin
                r_st[s] <= n_st[s];
            end
            r_odata <= n_odata;
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the saturating RGB pixel ALU: random and directed
// pixel transactions, a golden per-channel predictor and an in-order
// scoreboard, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    // Expected result of one pixel transaction.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       gt;
        logic       lt;
        logic       ge;
        logic       le;
        logic       eq;
        logic [7:0] min_c;
        logic [7:0] max_c;
        logic [7:0] avg_c;
        logic [8:0] len;
    } t_res;

    // Golden model of one channel operation.
    function automatic logic [7:0] chan_calc(logic [4:0] k, int unsigned a,
                                             int unsigned x, bit scal);
        int unsigned v;
        v = a;
        case (k)
            rgbalu_pkg::K_ADD:  v = (a + x > 255) ? 255 : a + x;
            rgbalu_pkg::K_SUB:  v = (a > x) ? a - x : 0;
            rgbalu_pkg::K_ABSD: v = (a > x) ? a - x : x - a;
            rgbalu_pkg::K_OR:   v = a | x;
            rgbalu_pkg::K_XOR:  v = a ^ x;
            rgbalu_pkg::K_AND:  v = a & x;
            rgbalu_pkg::K_DIV:  v = (x == 0) ? a : a / x;
            rgbalu_pkg::K_MOD:  v = (x == 0) ? (scal ? a : 0) : a % x;
            rgbalu_pkg::K_MUL:  v = scal ? ((a * x > 255) ? 255 : a * x)
                                         : (2 * a * x + 255) / 510;
            rgbalu_pkg::K_SHL:  v = (a == 0) ? 0 : (x >= 8) ? 255
                                    : (((a << x) > 255) ? 255 : (a << x));
            rgbalu_pkg::K_SHR:  v = (x >= 8) ? 0 : a >> x;
            rgbalu_pkg::K_INV:  v = 255 - a;
            rgbalu_pkg::K_INC:  v = (a + 1) & 255;
            rgbalu_pkg::K_DEC:  v = (a - 1) & 255;
            default: v = a;
        endcase
        return v[7:0];
    endfunction

    function automatic t_res pixel_predict(logic [4:0] k, rgbalu_pkg::t_pix a,
                                           rgbalu_pkg::t_pix b, bit scal,
                                           logic [7:0] s);
        t_res r;
        logic [7:0] o [3];
        int unsigned sq, root;
        // channel index 0 = red
        case (k)
            rgbalu_pkg::K_RBG: o = '{a[0], a[2], a[1]};
            rgbalu_pkg::K_GRB: o = '{a[1], a[0], a[2]};
            rgbalu_pkg::K_GBR: o = '{a[1], a[2], a[0]};
            rgbalu_pkg::K_BRG: o = '{a[2], a[0], a[1]};
            rgbalu_pkg::K_BGR: o = '{a[2], a[1], a[0]};
            default: for (int i = 0; i < 3; i++)
                o[i] = chan_calc(k, a[i], scal ? s : b[i], scal);
        endcase
        r.red = o[0]; r.green = o[1]; r.blue = o[2];
        r.gt = 1'b1; r.lt = 1'b1; r.ge = 1'b1; r.le = 1'b1; r.eq = 1'b1;
        r.min_c = a[0]; r.max_c = a[0];
        for (int i = 0; i < 3; i++) begin
            r.gt &= a[i] > b[i];  r.lt &= a[i] < b[i];
            r.ge &= a[i] >= b[i]; r.le &= a[i] <= b[i];
            r.eq &= a[i] == b[i];
            if (a[i] < r.min_c) r.min_c = a[i];
            if (a[i] > r.max_c) r.max_c = a[i];
        end
        r.avg_c = 8'((int'(a[0]) + a[1] + a[2]) / 3);
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        root = 0;
        while ((root + 1) * (root + 1) <= sq) root++;
        r.len = root[8:0];
        return r;
    endfunction

    class pixel_scoreboard;
        t_res pending[$];
        int   errors;

        function void note_input(logic [4:0] k, rgbalu_pkg::t_pix a,
                                 rgbalu_pkg::t_pix b, bit scal, logic [7:0] s);
            pending.push_back(pixel_predict(k, a, b, scal, s));
        endfunction

        function void check_result(logic [63:0] d);
            t_res e;
            t_res g;
            if (pending.size() == 0) begin
                $error("result with no pending expectation: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            g.red = d[7:0];    g.green = d[15:8]; g.blue = d[23:16];
            g.gt = d[24]; g.lt = d[25]; g.ge = d[26]; g.le = d[27]; g.eq = d[28];
            g.min_c = d[36:29]; g.max_c = d[44:37]; g.avg_c = d[52:45];
            g.len = d[61:53];
            if (g.red != e.red) begin
                $error("out_red exp %0d got %0d", e.red, g.red); errors++; end
            if (g.green != e.green) begin
                $error("out_green exp %0d got %0d", e.green, g.green); errors++; end
            if (g.blue != e.blue) begin
                $error("out_blue exp %0d got %0d", e.blue, g.blue); errors++; end
            if (g.gt != e.gt) begin
                $error("all_greater exp %0d got %0d", e.gt, g.gt); errors++; end
            if (g.lt != e.lt) begin
                $error("all_less exp %0d got %0d", e.lt, g.lt); errors++; end
            if (g.ge != e.ge) begin
                $error("all_greater_equal exp %0d got %0d", e.ge, g.ge); errors++; end
            if (g.le != e.le) begin
                $error("all_less_equal exp %0d got %0d", e.le, g.le); errors++; end
            if (g.eq != e.eq) begin
                $error("all_equal exp %0d got %0d", e.eq, g.eq); errors++; end
            if (g.min_c != e.min_c) begin
                $error("min_channel exp %0d got %0d", e.min_c, g.min_c); errors++; end
            if (g.max_c != e.max_c) begin
                $error("max_channel exp %0d got %0d", e.max_c, g.max_c); errors++; end
            if (g.avg_c != e.avg_c) begin
                $error("average_channel exp %0d got %0d", e.avg_c, g.avg_c); errors++; end
            if (g.len != e.len) begin
                $error("vector_length exp %0d got %0d", e.len, g.len); errors++; end
            if (d[63:62] != 2'b00) begin
                $error("zero pad exp 0 got %0d", d[63:62]); errors++; end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [55:0] s_data = '0;
    logic [5:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;

    pixel_scoreboard board = new();
    int          send_idle_pct = 15;
    int          recv_idle_pct = 61;
    bit          recv_hold = 1'b0;
    int unsigned cycle_count = 0;
    localparam int unsigned CYCLE_LIMIT = 400000;

    saturating_rgb_pixel_alu dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // a_red .. b_blue, scalar_operand
        .i_s_axis_tuser  (s_user),   // kind[4:0], use_scalar[5]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // results, see scoreboard unpacking
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: check each accepted result, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            board.check_result(m_data);
        if (!i_rst_n || recv_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one transaction and hold it until accepted; score it on acceptance.
    task automatic send_pixel(logic [4:0] k, rgbalu_pkg::t_pix a,
                              rgbalu_pkg::t_pix b, bit scal, logic [7:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {s, b[2], b[1], b[0], a[2], a[1], a[0]};
        s_user  <= {scal, k};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        board.note_input(k, a, b, scal, s);
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        drop_valid();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(8));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random();
        logic [4:0] k;
        rgbalu_pkg::t_pix a, b;
        logic [7:0] s;
        k = ($urandom_range(19) == 0) ? 5'($urandom_range(31))
                                      : 5'($urandom_range(18));
        for (int i = 0; i < 3; i++) begin
            a[i] = rand_chan();
            // make equal channels common so compare flags toggle
            b[i] = ($urandom_range(4) == 0) ? a[i] : rand_chan();
        end
        s = (k == rgbalu_pkg::K_SHL || k == rgbalu_pkg::K_SHR)
            ? 8'($urandom_range(12)) : rand_chan();
        send_pixel(k, a, b, 1'($urandom_range(1)), s);
    endtask

    initial begin
        rgbalu_pkg::t_pix zero_p, full_p, mix_p;
        zero_p = '{8'd0, 8'd0, 8'd0};
        full_p = '{8'd255, 8'd255, 8'd255};
        mix_p  = '{8'd200, 8'd7, 8'd0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation on extreme and mixed pixels.
        for (int k = 0; k <= 18; k++)
            send_pixel(5'(k), mix_p, '{8'd3, 8'd7, 8'd255}, k[0], 8'd3);
        send_pixel(rgbalu_pkg::K_DIV, full_p, zero_p, 1'b0, 8'd0);  // divide by zero pixel
        send_pixel(rgbalu_pkg::K_DIV, mix_p, zero_p, 1'b1, 8'd0);   // divide by zero scalar
        send_pixel(rgbalu_pkg::K_MOD, full_p, zero_p, 1'b0, 8'd0);  // pixel modulo by zero
        send_pixel(rgbalu_pkg::K_MOD, full_p, zero_p, 1'b1, 8'd0);  // scalar modulo by zero
        send_pixel(rgbalu_pkg::K_SHL, '{8'd1, 8'd0, 8'd255}, zero_p, 1'b1,
                   8'd200);                                         // big shift
        send_pixel(rgbalu_pkg::K_SHR, full_p, full_p, 1'b1, 8'd8);
        send_pixel(rgbalu_pkg::K_MUL, full_p, full_p, 1'b0, 8'd255);
        send_pixel(5'd31, full_p, zero_p, 1'b1, 8'd255);            // undefined kind

        // Pause until every result is back.
        drain();

        // Long receiver stall while the sender keeps offering.
        recv_hold = 1'b1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            repeat (20) send_random();
        join
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 61 : 0;
            recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 15 : 0;
            repeat (500) send_random();
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
